[hw/rtl/ssfce_pkg.sv]
// ssfce_pkg: shared types, opcodes and constants of the spi serial flash command engine
// used by the engine top level and its checker
`timescale 1ns / 1ps

package ssfce_pkg;

  // address space
  localparam int unsigned MAX_ADDR_BITS = 20;
  localparam int unsigned MIN_ADDR_BITS = 18;
  localparam int unsigned BYTE_ADDR_W   = 24;

  // page and sector geometry
  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned SECTOR_BYTES = 65536;
  localparam int unsigned PAGE_BITS    = $clog2(PAGE_BYTES);
  localparam int unsigned SECTOR_BITS  = $clog2(SECTOR_BYTES);
  localparam logic [SECTOR_BITS-1:0] PAGE_LAST   = SECTOR_BITS'(PAGE_BYTES - 1);
  localparam logic [SECTOR_BITS-1:0] SECTOR_LAST = SECTOR_BITS'(SECTOR_BYTES - 1);

  // byte values
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] STATUS_WEL = 8'h02;
  localparam logic [7:0] STATUS_CLR = 8'h00;

  // identity bytes returned by the id read
  localparam logic [BYTE_ADDR_W-1:0] ID_BYTES = 24'd3;

  // configuration register indexes
  localparam logic CFG_SIZE_SELECT    = 1'b0;
  localparam logic CFG_JEDEC_IDENTITY = 1'b1;

  // operation codes of an input beat
  localparam logic OPER_TRANSFER = 1'b0;
  localparam logic OPER_RELEASE  = 1'b1;

  // command opcodes
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_WRDI = 8'h04;
  localparam logic [7:0] OP_RDID = 8'h9F;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_FAST = 8'h0B;
  localparam logic [7:0] OP_PW   = 8'h0A;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_PE   = 8'hDB;
  localparam logic [7:0] OP_SE   = 8'hD8;
  localparam logic [7:0] OP_DP   = 8'hB9;
  localparam logic [7:0] OP_RDP  = 8'hAB;

  // latched command
  typedef enum logic [3:0] {
    CMD_NONE = 4'd0,
    CMD_WREN = 4'd1,
    CMD_WRDI = 4'd2,
    CMD_RDID = 4'd3,
    CMD_RDSR = 4'd4,
    CMD_READ = 4'd5,
    CMD_FAST = 4'd6,
    CMD_PW   = 4'd7,
    CMD_PP   = 4'd8,
    CMD_PE   = 4'd9,
    CMD_SE   = 4'd10,
    CMD_DP   = 4'd11,
    CMD_RDP  = 4'd12
  } cmd_e;

  // protocol phase within a selected transaction
  typedef enum logic [11:0] {
    PH_CMD    = 12'b0000_0000_0001,
    PH_ID     = 12'b0000_0000_0010,
    PH_STATUS = 12'b0000_0000_0100,
    PH_A0     = 12'b0000_0000_1000,
    PH_A1     = 12'b0000_0001_0000,
    PH_A2     = 12'b0000_0010_0000,
    PH_DUMMY  = 12'b0000_0100_0000,
    PH_READ   = 12'b0000_1000_0000,
    PH_PW     = 12'b0001_0000_0000,
    PH_PP     = 12'b0010_0000_0000,
    PH_PE     = 12'b0100_0000_0000,
    PH_SE     = 12'b1000_0000_0000
  } phase_e;

  // engine sequencer
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_PPWR  = 4'b0100,
    ST_ERASE = 4'b1000
  } ctrl_state_e;

  function automatic cmd_e decode_opcode(input logic [7:0] op);
    cmd_e c;
    case (op)
      OP_WREN: c = CMD_WREN;
      OP_WRDI: c = CMD_WRDI;
      OP_RDID: c = CMD_RDID;
      OP_RDSR: c = CMD_RDSR;
      OP_READ: c = CMD_READ;
      OP_FAST: c = CMD_FAST;
      OP_PW:   c = CMD_PW;
      OP_PP:   c = CMD_PP;
      OP_PE:   c = CMD_PE;
      OP_SE:   c = CMD_SE;
      OP_DP:   c = CMD_DP;
      OP_RDP:  c = CMD_RDP;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/ssfce_store.sv]
// ssfce_store: flash array, one write port and one read port, registered read data
// depends on nothing but its address width parameter
`timescale 1ns / 1ps

module ssfce_store #(
  parameter int unsigned AddrBits = 20
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [7:0]          wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [7:0]          rdata_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/spi_serial_flash_command_engine.sv]
// spi_serial_flash_command_engine: byte level command decoder of a serial flash
// depends on ssfce_pkg and ssfce_store
// results: each beat's result is strobed the cycle after it is accepted, but page program,
//   page erase and sector erase strobe once their write-back or sweep ends (busy held meanwhile)
// throughput: one beat per cycle for all other beats; set by the single write port of the
//   storage memory, which the read-modify-write and the erase sweeps occupy
// reset: busy stays high while a clearing pass writes 0xFF to every byte, one per cycle;
//   configuration writes are taken throughout
`timescale 1ns / 1ps

module spi_serial_flash_command_engine #(
  parameter int unsigned MaxAddrBits = ssfce_pkg::MAX_ADDR_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [7:0]  data_in_i,
  // result channel
  output logic        strobe_o,
  output logic [7:0]  data_out_o,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam int unsigned AW = MaxAddrBits;
  localparam int unsigned BW = ssfce_pkg::BYTE_ADDR_W;
  localparam int unsigned PB = ssfce_pkg::PAGE_BITS;
  localparam int unsigned SB = ssfce_pkg::SECTOR_BITS;

  // capacity mask: 18 + size select bits, select 3 as 1 MiB, never above the array
  function automatic logic [AW-1:0] size_mask(input logic [1:0] sel);
    int unsigned bits;
    logic [AW-1:0] m;
    bits = ssfce_pkg::MIN_ADDR_BITS + ((sel > 2'd2) ? 2 : int'(sel));
    for (int k = 0; k < AW; k++) begin
      m[k] = (k < bits);
    end
    return m;
  endfunction

  // sequencer and transaction state
  ssfce_pkg::ctrl_state_e state_q, state_d;
  ssfce_pkg::phase_e      phase_q, phase_d;
  ssfce_pkg::cmd_e        cmd_q, cmd_d;
  logic [BW-1:0]          addr_q, addr_d;
  logic                   wel_q, wel_d;
  logic                   dpd_q, dpd_d;
  logic [AW-1:0]          cnt_q, cnt_d;
  logic                   sector_q, sector_d;
  logic [7:0]             pdata_q, pdata_d;

  // configuration
  logic [1:0]             size_q, size_d;
  logic [23:0]            jedec_q, jedec_d;

  // result register
  logic                   strobe_q, strobe_d;
  logic [7:0]             dout_q, dout_d;
  logic                   rdsel_q, rdsel_d;

  // memory port
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata, mem_rdata;

  logic                   accept;
  logic [AW-1:0]          mask;
  logic [AW-1:0]          addr_m;
  logic [BW-1:0]          addr_nip;
  ssfce_pkg::cmd_e        dec_cmd;

  assign busy     = (state_q != ssfce_pkg::ST_RUN);
  assign accept   = start && !busy;
  assign mask     = size_mask(size_q);
  assign addr_m   = addr_q[AW-1:0] & mask;
  // next address, wrapping within the page
  assign addr_nip = {addr_q[BW-1:PB], addr_q[PB-1:0] + 1'b1};
  assign dec_cmd  = ssfce_pkg::decode_opcode(data_in_i);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    wel_d     = wel_q;
    dpd_d     = dpd_q;
    cnt_d     = cnt_q;
    sector_d  = sector_q;
    pdata_d   = pdata_q;
    size_d    = size_q;
    jedec_d   = jedec_q;
    strobe_d  = 1'b0;
    dout_d    = ssfce_pkg::BYTE_IDLE;
    rdsel_d   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = ssfce_pkg::BYTE_IDLE;
    mem_re    = 1'b0;
    mem_raddr = addr_m;

    // register writes: the user must issue them only while idle; the block does not enforce this
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ssfce_pkg::CFG_SIZE_SELECT:    size_d  = cfg_wdata_i[1:0];
        ssfce_pkg::CFG_JEDEC_IDENTITY: jedec_d = cfg_wdata_i;
        default:                       size_d  = size_q;
      endcase
    end

    case (state_q)
      // clearing pass after reset: every byte to the erased value
      ssfce_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          cnt_d   = '0;
          state_d = ssfce_pkg::ST_RUN;
        end
      end

      ssfce_pkg::ST_RUN: begin
        if (accept) begin
          strobe_d = 1'b1;
          if (operation_i == ssfce_pkg::OPER_RELEASE) begin
            // chip select released: write commands drop the latch
            if (cmd_q == ssfce_pkg::CMD_PW || cmd_q == ssfce_pkg::CMD_PP ||
                cmd_q == ssfce_pkg::CMD_PE || cmd_q == ssfce_pkg::CMD_SE) begin
              wel_d = 1'b0;
            end
            phase_d = ssfce_pkg::PH_CMD;
          end else begin
            case (phase_q)
              ssfce_pkg::PH_CMD: begin
                if (dpd_q) begin
                  // deep power down: only the release opcode is heard
                  if (dec_cmd == ssfce_pkg::CMD_RDP) begin
                    dpd_d = 1'b0;
                  end
                end else begin
                  cmd_d = dec_cmd;
                  case (dec_cmd)
                    ssfce_pkg::CMD_WREN: wel_d = 1'b1;
                    ssfce_pkg::CMD_WRDI: wel_d = 1'b0;
                    ssfce_pkg::CMD_RDID: begin
                      addr_d  = '0;
                      phase_d = ssfce_pkg::PH_ID;
                    end
                    ssfce_pkg::CMD_RDSR: phase_d = ssfce_pkg::PH_STATUS;
                    ssfce_pkg::CMD_READ,
                    ssfce_pkg::CMD_FAST: phase_d = ssfce_pkg::PH_A0;
                    ssfce_pkg::CMD_PW,
                    ssfce_pkg::CMD_PP,
                    ssfce_pkg::CMD_PE,
                    ssfce_pkg::CMD_SE: begin
                      if (wel_q) begin
                        phase_d = ssfce_pkg::PH_A0;
                      end
                    end
                    ssfce_pkg::CMD_DP:   dpd_d = 1'b1;
                    default:             cmd_d = dec_cmd;
                  endcase
                end
              end
              ssfce_pkg::PH_ID: begin
                if (addr_q < ssfce_pkg::ID_BYTES) begin
                  addr_d = addr_q + 1'b1;
                  case (addr_q[1:0])
                    2'd0:    dout_d = jedec_q[23:16];
                    2'd1:    dout_d = jedec_q[15:8];
                    default: dout_d = jedec_q[7:0];
                  endcase
                end
              end
              ssfce_pkg::PH_STATUS: begin
                dout_d = wel_q ? ssfce_pkg::STATUS_WEL : ssfce_pkg::STATUS_CLR;
              end
              ssfce_pkg::PH_A0: begin
                addr_d  = {data_in_i, 16'h0000};
                phase_d = ssfce_pkg::PH_A1;
              end
              ssfce_pkg::PH_A1: begin
                addr_d  = {addr_q[23:16], data_in_i, 8'h00};
                phase_d = ssfce_pkg::PH_A2;
              end
              ssfce_pkg::PH_A2: begin
                addr_d = {addr_q[23:8], data_in_i};
                case (cmd_q)
                  ssfce_pkg::CMD_READ: phase_d = ssfce_pkg::PH_READ;
                  ssfce_pkg::CMD_FAST: phase_d = ssfce_pkg::PH_DUMMY;
                  ssfce_pkg::CMD_PW:   phase_d = ssfce_pkg::PH_PW;
                  ssfce_pkg::CMD_PP:   phase_d = ssfce_pkg::PH_PP;
                  ssfce_pkg::CMD_PE:   phase_d = ssfce_pkg::PH_PE;
                  ssfce_pkg::CMD_SE:   phase_d = ssfce_pkg::PH_SE;
                  default:             phase_d = ssfce_pkg::PH_CMD;
                endcase
              end
              ssfce_pkg::PH_DUMMY: phase_d = ssfce_pkg::PH_READ;
              ssfce_pkg::PH_READ: begin
                // data comes straight off the memory in the strobe cycle
                mem_re  = 1'b1;
                rdsel_d = 1'b1;
                addr_d  = addr_q + 1'b1;
              end
              ssfce_pkg::PH_PW: begin
                mem_we    = 1'b1;
                mem_waddr = addr_m;
                mem_wdata = data_in_i;
                addr_d    = addr_nip;
              end
              ssfce_pkg::PH_PP: begin
                // read now, write the and-ed byte next cycle
                mem_re   = 1'b1;
                pdata_d  = data_in_i;
                strobe_d = 1'b0;
                state_d  = ssfce_pkg::ST_PPWR;
              end
              ssfce_pkg::PH_PE: begin
                addr_d   = {addr_q[BW-1:PB], PB'(0)};
                sector_d = 1'b0;
                cnt_d    = '0;
                strobe_d = 1'b0;
                state_d  = ssfce_pkg::ST_ERASE;
              end
              ssfce_pkg::PH_SE: begin
                addr_d   = {addr_q[BW-1:SB], SB'(0)};
                sector_d = 1'b1;
                cnt_d    = '0;
                strobe_d = 1'b0;
                state_d  = ssfce_pkg::ST_ERASE;
              end
              default: phase_d = ssfce_pkg::PH_CMD;
            endcase
          end
        end
      end

      // write-back half of a page program, busy interlocks the port
      ssfce_pkg::ST_PPWR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_m;
        mem_wdata = mem_rdata & pdata_q;
        addr_d    = addr_nip;
        strobe_d  = 1'b1;
        state_d   = ssfce_pkg::ST_RUN;
      end

      // erase sweep over the page or sector, one byte a cycle
      ssfce_pkg::ST_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = (addr_q[AW-1:0] | cnt_q) & mask;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[SB-1:0] == (sector_q ? ssfce_pkg::SECTOR_LAST : ssfce_pkg::PAGE_LAST)) begin
          cnt_d    = '0;
          strobe_d = 1'b1;
          state_d  = ssfce_pkg::ST_RUN;
        end
      end

      default: state_d = ssfce_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ssfce_pkg::ST_CLEAR;
      phase_q  <= ssfce_pkg::PH_CMD;
      cmd_q    <= ssfce_pkg::CMD_NONE;
      addr_q   <= '0;
      wel_q    <= 1'b0;
      dpd_q    <= 1'b0;
      cnt_q    <= '0;
      sector_q <= 1'b0;
      size_q   <= '0;
      jedec_q  <= '0;
      strobe_q <= 1'b0;
      rdsel_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      addr_q   <= addr_d;
      wel_q    <= wel_d;
      dpd_q    <= dpd_d;
      cnt_q    <= cnt_d;
      sector_q <= sector_d;
      size_q   <= size_d;
      jedec_q  <= jedec_d;
      strobe_q <= strobe_d;
      rdsel_q  <= rdsel_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pdata_q <= pdata_d;
    dout_q  <= dout_d;
  end

  ssfce_store #(
    .AddrBits(AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign strobe_o   = strobe_q;
  assign data_out_o = rdsel_q ? mem_rdata : dout_q;

endmodule

[hw/rtl/ssfce_checker.sv]
// ssfce_checker: port level checks of the serial flash command engine, with its bind
// depends on ssfce_pkg and spi_serial_flash_command_engine
`timescale 1ns / 1ps

module ssfce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       operation_i,
  input logic       strobe_o,
  input logic [7:0] data_out_o
);

  // a release beat answers with the idle byte next cycle
  a_release_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i) |=> (strobe_o && data_out_o == ssfce_pkg::BYTE_IDLE))
    else $error("release beat not answered with idle byte");

  // a transfer beat is either answered next cycle or starts a busy operation
  a_transfer_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !operation_i) |=> (strobe_o || busy))
    else $error("transfer beat neither answered nor busy");

  // a result never shows while the engine is still busy
  a_no_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result strobed while busy");

  // every result follows an accepted beat or the end of a busy operation
  a_strobe_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobed without a cause");

endmodule

bind spi_serial_flash_command_engine ssfce_checker u_ssfce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .operation_i(operation_i),
  .strobe_o   (strobe_o),
  .data_out_o (data_out_o)
);
